>>> src/tmlcs_pkg.sv
package tmlcs_pkg;

   localparam int NUM_CH    = 4;
   localparam int CH_W      = 2;
   localparam int SAMPLE_W  = 12;
   localparam int SUM_W     = 15;
   localparam int ROUNDS    = 6;
   localparam int ROUND_W   = 3;
   localparam int GAIN_W    = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CAF_W     = 11;
   localparam int VAL_W     = 20;
   localparam int CUR_W     = 13;
   localparam int MUL_W     = 22;
   localparam int PROD_W    = 2 * MUL_W;

   // 336000 / (4096*148) reduced: x*2625 >> 7, then / 37
   localparam int SCALE_NUM_RED = 2625;
   localparam int SCALE_SHIFT   = 7;
   localparam int DIV_A         = 37;
   localparam int RECIP_A_SHIFT = 22;
   localparam int RECIP_A       = (1 << RECIP_A_SHIFT) / DIV_A;

   localparam int FLOOR_OFFSET = 400;
   localparam int CAF_MAX      = 1869;

   // divide by 160: >> 5, then / 5
   localparam int GAIN_SHIFT    = 5;
   localparam int DIV_B         = 5;
   localparam int RECIP_B_SHIFT = 24;
   localparam int RECIP_B       = (1 << RECIP_B_SHIFT) / DIV_B;

   typedef enum logic [2:0] {
      STEP_NONE,
      STEP_TRIM,
      STEP_RECIP_A,
      STEP_FIX_A,
      STEP_GAIN,
      STEP_RECIP_B,
      STEP_FIX_B,
      STEP_LOAD
   } step_type;

   typedef struct packed {
      logic            accum;
      logic            clear;
      step_type        step;
      logic [CH_W-1:0] ch;
   } cmd_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_ch0;
      logic [SAMPLE_W-1:0] sample_ch1;
      logic [SAMPLE_W-1:0] sample_ch2;
      logic [SAMPLE_W-1:0] sample_ch3;
   } req_type;

   typedef struct packed {
      logic [CH_W-1:0]  channel;
      logic [CAF_W-1:0] current_above_floor;
      logic [VAL_W-1:0] scaled_value;
      logic             last;
   } rsp_type;

endpackage

>>> src/trimmed_mean_loop_current_scaler_unit.sv
// Trimmed-mean 4-20 mA loop current scaler.
//
// req channel: one transaction is one round of four 12-bit samples, one per
// channel. Rounds that do not finish a burst are taken one per cycle and
// only update the per-channel sum, minimum and maximum.
// The round that brings the count to ROUNDS starts a burst: req_stall goes
// high and four rsp transactions follow in channel order, last set on
// channel 3. Each result runs through one shared 22x22 multiplier
// (scale, two reciprocal divides with correction, gain) in the states trim,
// recip A, fix A, gain, recip B, fix B and load. The first result starts
// once the final round is taken, and each further one only once the previous
// result is taken, so one result is in flight at a time. After the last
// result is taken the accumulators clear and req reopens on the next cycle.
// While rsp_stall is high the pending result holds and the sequencer waits.
// csr port: gain registers 0..3, written any cycle with csr_wr_en.
// Reset (synchronous): round count and sums to zero, minimums to 4095,
// maximums to zero, gains to 1, no result pending.
module trimmed_mean_loop_current_scaler_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  tmlcs_pkg::req_type              req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output tmlcs_pkg::rsp_type              rsp_payload,
   input  logic                            csr_wr_en,
   input  logic [tmlcs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tmlcs_pkg::GAIN_W-1:0]    csr_wdata
);
   import tmlcs_pkg::*;

   // controller -> datapath commands: accumulate, clear, step, channel
   cmd_type cmd;

   tmlcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // accumulators, gain registers, shared multiplier, result register
   tmlcs_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> src/tmlcs_ctrl.sv
module tmlcs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tmlcs_pkg::cmd_type cmd
);
   import tmlcs_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_TRIM     = 9'b000000010,
      ST_RECIP_A  = 9'b000000100,
      ST_FIX_A    = 9'b000001000,
      ST_GAIN     = 9'b000010000,
      ST_RECIP_B  = 9'b000100000,
      ST_FIX_B    = 9'b001000000,
      ST_LOAD     = 9'b010000000,
      ST_WAIT     = 9'b100000000
   } state_type;

   state_type           state_ff, state_in;
   logic [CH_W-1:0]     ch_ff, ch_in;
   logic [ROUND_W-1:0]  round_ff, round_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                req_take, rsp_take;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign req_take  = req_valid & ~req_stall;
   assign rsp_take  = rsp_valid_ff & ~rsp_stall;

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      round_in     = round_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd.accum    = 1'b0;
      cmd.clear    = 1'b0;
      cmd.step     = STEP_NONE;
      cmd.ch       = ch_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cmd.accum = 1'b1;
               if (round_ff == ROUND_W'(ROUNDS - 1)) begin
                  round_in = '0;
                  ch_in    = '0;
                  state_in = ST_TRIM;
               end else begin
                  round_in = round_ff + ROUND_W'(1);
               end
            end
         end
         ST_TRIM: begin
            cmd.step = STEP_TRIM;
            state_in = ST_RECIP_A;
         end
         ST_RECIP_A: begin
            cmd.step = STEP_RECIP_A;
            state_in = ST_FIX_A;
         end
         ST_FIX_A: begin
            cmd.step = STEP_FIX_A;
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            cmd.step = STEP_GAIN;
            state_in = ST_RECIP_B;
         end
         ST_RECIP_B: begin
            cmd.step = STEP_RECIP_B;
            state_in = ST_FIX_B;
         end
         ST_FIX_B: begin
            cmd.step = STEP_FIX_B;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.step     = STEP_LOAD;
            rsp_valid_in = 1'b1;
            state_in     = ST_WAIT;
         end
         ST_WAIT: begin
            if (rsp_take) begin
               rsp_valid_in = 1'b0;
               if (ch_ff == CH_W'(NUM_CH - 1)) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  ch_in    = ch_ff + CH_W'(1);
                  state_in = ST_TRIM;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= '0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_accept_during_burst: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("input open while a result is pending");

   a_reopen_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && ch_ff == CH_W'(NUM_CH - 1)) |=> !req_stall)
      else $error("input not reopened after last result");

   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      round_ff < ROUND_W'(ROUNDS))
      else $error("round count past limit");
`endif

endmodule

>>> src/tmlcs_dpath.sv
module tmlcs_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  tmlcs_pkg::cmd_type             cmd,
   input  tmlcs_pkg::req_type             req_payload,
   input  logic                           csr_wr_en,
   input  logic [tmlcs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tmlcs_pkg::GAIN_W-1:0]   csr_wdata,
   output tmlcs_pkg::rsp_type             rsp_payload
);
   import tmlcs_pkg::*;

   logic [SAMPLE_W-1:0] samp [NUM_CH];
   logic [SUM_W-1:0]    sum_ff [NUM_CH];
   logic [SAMPLE_W-1:0] min_ff [NUM_CH];
   logic [SAMPLE_W-1:0] max_ff [NUM_CH];
   logic [GAIN_W-1:0]   gain_ff [NUM_CH];

   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [MUL_W-1:0]    hold_ff, hold_in;
   logic [VAL_W-1:0]    q_ff, q_in;
   logic [CAF_W-1:0]    caf_ff, caf_in;
   rsp_type             rsp_ff, rsp_in;

   logic [MUL_W-1:0]    mul_a, mul_b;
   logic [SUM_W-1:0]    trim, rest;
   logic [MUL_W-1:0]    rem;
   logic [CUR_W-1:0]    cur;
   logic [CAF_W-1:0]    caf;
   logic [VAL_W-1:0]    val;

   assign samp[0] = req_payload.sample_ch0;
   assign samp[1] = req_payload.sample_ch1;
   assign samp[2] = req_payload.sample_ch2;
   assign samp[3] = req_payload.sample_ch3;

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int c = 0; c < NUM_CH; c++) begin
            sum_ff[c] <= '0;
            min_ff[c] <= '1;
            max_ff[c] <= '0;
         end
      end else if (cmd.accum) begin
         for (int c = 0; c < NUM_CH; c++) begin
            sum_ff[c] <= sum_ff[c] + SUM_W'(samp[c]);
            if (samp[c] < min_ff[c]) min_ff[c] <= samp[c];
            if (samp[c] > max_ff[c]) max_ff[c] <= samp[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CH; c++) gain_ff[c] <= GAIN_W'(1);
      end else if (csr_wr_en) begin
         gain_ff[csr_index] <= csr_wdata;
      end
   end

   // trimmed sum, clamped
   assign trim = SUM_W'(min_ff[cmd.ch]) + SUM_W'(max_ff[cmd.ch]);
   assign rest = (sum_ff[cmd.ch] >= trim) ? (sum_ff[cmd.ch] - trim) : '0;

   // remainder check for both reciprocal divides
   assign rem = hold_ff - prod_ff[MUL_W-1:0];
   assign cur = CUR_W'(q_ff) + CUR_W'(rem >= MUL_W'(DIV_A));
   assign caf = (cur >= CUR_W'(FLOOR_OFFSET)) ? CAF_W'(cur - CUR_W'(FLOOR_OFFSET)) : '0;
   assign val = q_ff + VAL_W'(rem >= MUL_W'(DIV_B));

   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      hold_in = hold_ff;
      q_in   = q_ff;
      caf_in = caf_ff;
      rsp_in = rsp_ff;
      unique case (cmd.step)
         STEP_TRIM: begin
            mul_a = MUL_W'(rest >> 2);
            mul_b = MUL_W'(SCALE_NUM_RED);
         end
         STEP_RECIP_A: begin
            hold_in = MUL_W'(prod_ff >> SCALE_SHIFT);
            mul_a   = hold_in;
            mul_b   = MUL_W'(RECIP_A);
         end
         STEP_FIX_A: begin
            q_in  = VAL_W'(prod_ff >> RECIP_A_SHIFT);
            mul_a = MUL_W'(q_in);
            mul_b = MUL_W'(DIV_A);
         end
         STEP_GAIN: begin
            caf_in = caf;
            mul_a  = MUL_W'(caf);
            mul_b  = MUL_W'(gain_ff[cmd.ch]);
         end
         STEP_RECIP_B: begin
            hold_in = MUL_W'(prod_ff >> GAIN_SHIFT);
            mul_a   = hold_in;
            mul_b   = MUL_W'(RECIP_B);
         end
         STEP_FIX_B: begin
            q_in  = VAL_W'(prod_ff >> RECIP_B_SHIFT);
            mul_a = MUL_W'(q_in);
            mul_b = MUL_W'(DIV_B);
         end
         STEP_LOAD: begin
            rsp_in.channel             = cmd.ch;
            rsp_in.current_above_floor = caf_ff;
            rsp_in.scaled_value        = val;
            rsp_in.last                = (cmd.ch == CH_W'(NUM_CH - 1));
         end
         STEP_NONE: begin
         end
         default: begin
         end
      endcase
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      hold_ff <= hold_in;
      q_ff    <= q_in;
      caf_ff  <= caf_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   a_fix_a_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.step == STEP_GAIN) |-> (rem < MUL_W'(2 * DIV_A)))
      else $error("divide by 37 needs more than one correction");

   a_fix_b_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.step == STEP_LOAD) |-> (rem < MUL_W'(2 * DIV_B)))
      else $error("divide by 5 needs more than one correction");

   a_caf_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.step == STEP_GAIN) |-> (caf <= CAF_W'(CAF_MAX)))
      else $error("current above floor out of range");
`endif

endmodule
